// File: rtl/core/image_half_downsampler_unit_assert.svh
// Assertion macros for the half downsampler.
`ifndef IMAGE_HALF_DOWNSAMPLER_UNIT_ASSERT_SVH
`define IMAGE_HALF_DOWNSAMPLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define IHD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("ihd assertion failed");

// Next-cycle implication, disabled during reset.
`define IHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("ihd assertion failed");

`endif

// File: rtl/core/ihd_pkg.sv
// Shared constants, types and helpers of the half downsampler.
package ihd_pkg;

	localparam int MAX_WIDTH    = 2048;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int WIDTH_REG_W  = 12;
	localparam int HEIGHT_REG_W = 13;
	localparam int ROW_W        = 12;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int PIX_W        = 8;
	localparam int EW_MIN_W     = $clog2(MAX_WIDTH + 1);
	localparam int EW_W         = (EW_MIN_W > WIDTH_REG_W) ? EW_MIN_W : WIDTH_REG_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_IMAGE_WIDTH  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_IMAGE_HEIGHT = cfg_idx_t'(1);

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	// Position of the pixel being transferred, its parity bits and end-of-row/frame flags
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic             row_odd;
		logic             col_odd;
		logic             row_end;
		logic             frame_end;
	} pos_t;

	typedef struct packed {
		logic s1_valid;
		logic s1_free;
		logic s1_has_result;
	} avg_status_t;

	function automatic logic [EW_W-1:0] clamp_width(input logic [WIDTH_REG_W-1:0] w);
		logic [EW_W-1:0] ext;
		ext = EW_W'(w);
		if (ext < EW_W'(2))
			return EW_W'(2);
		else if (ext > EW_W'(MAX_WIDTH))
			return EW_W'(MAX_WIDTH);
		else
			return ext;
	endfunction

	function automatic logic [HEIGHT_REG_W-1:0] clamp_height(
		input logic [HEIGHT_REG_W-1:0] h);
		if (h < HEIGHT_REG_W'(2))
			return HEIGHT_REG_W'(2);
		else if (h > HEIGHT_REG_W'(HEIGHT_LIMIT))
			return HEIGHT_REG_W'(HEIGHT_LIMIT);
		else
			return h;
	endfunction

	function automatic logic [PIX_W-1:0] round_avg(input logic [PIX_W-1:0] a,
		input logic [PIX_W-1:0] b);
		logic [PIX_W:0] sum;
		sum = (PIX_W+1)'(a) + (PIX_W+1)'(b) + (PIX_W+1)'(1);
		return sum[PIX_W:1];
	endfunction

endpackage

// File: rtl/core/pixel_in_if.sv
// Input pixel channel.
interface pixel_in_if;
	logic                      valid;
	logic                      ready;
	logic [ihd_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: rtl/core/pixel_out_if.sv
// Output pixel channel.
interface pixel_out_if;
	logic                      valid;
	logic                      ready;
	logic [ihd_pkg::PIX_W-1:0] pixel_out;
	logic                      row_end;
	logic                      frame_end;

	modport source (output valid, output pixel_out, output row_end, output frame_end,
		input ready);
	modport sink   (input valid, input pixel_out, input row_end, input frame_end,
		output ready);
endinterface

// File: rtl/core/cfg_write_if.sv
// Configuration register write channel.
interface cfg_write_if;
	logic                           valid;
	logic                           ready;
	logic [ihd_pkg::CFG_IDX_W-1:0]  index;
	logic [ihd_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/ihd_line_store.sv
// Line store: one source row of pixels, registered read.
module ihd_line_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [ihd_pkg::COL_W-1:0] wr_addr,
	input  logic [ihd_pkg::PIX_W-1:0] wr_data,
	input  logic                      rd_en,
	input  logic [ihd_pkg::COL_W-1:0] rd_addr,
	output logic [ihd_pkg::PIX_W-1:0] rd_data
);
	import ihd_pkg::*;

	logic [PIX_W-1:0] mem [MAX_WIDTH];
	logic [PIX_W-1:0] rd_data_s1;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_s1 <= mem[rd_addr];
	end

	assign rd_data = rd_data_s1;
endmodule

// File: rtl/core/ihd_position.sv
// Config registers and raster column/row counters.
module ihd_position (
	input  logic          clk,
	input  logic          arst_n,
	cfg_write_if.sink     cfg,
	input  logic          advance,
	output ihd_pkg::pos_t pos
);
	import ihd_pkg::*;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0]        col_q;
	logic [ROW_W-1:0]        row_q;

	logic [EW_W-1:0]         w_eff;
	logic [HEIGHT_REG_W-1:0] h_eff;
	logic [EW_W-1:0]         last_col;
	logic [HEIGHT_REG_W-1:0] last_row;
	logic                    col_wrap;
	logic                    row_wrap;

	assign cfg.ready = 1'b1;

	assign w_eff    = clamp_width(width_q);
	assign h_eff    = clamp_height(height_q);
	assign last_col = {w_eff[EW_W-1:1], 1'b0} - EW_W'(1);
	assign last_row = {h_eff[HEIGHT_REG_W-1:1], 1'b0} - HEIGHT_REG_W'(1);

	// >= so a counter left beyond a shrunk size wraps at its next advance
	assign col_wrap = (EW_W'(col_q) + EW_W'(1)) >= w_eff;
	assign row_wrap = (HEIGHT_REG_W'(row_q) + HEIGHT_REG_W'(1)) >= h_eff;

	always_comb begin
		pos.col       = col_q;
		pos.row_odd   = row_q[0];
		pos.col_odd   = col_q[0];
		pos.row_end   = EW_W'(col_q) == last_col;
		pos.frame_end = (EW_W'(col_q) == last_col) && (HEIGHT_REG_W'(row_q) == last_row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data[WIDTH_REG_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.data[HEIGHT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end
endmodule

// File: rtl/core/ihd_average.sv
// Vertical and horizontal rounding averages, held average and output register.
module ihd_average (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      load,
	input  ihd_pkg::pos_t             pos,
	input  logic [ihd_pkg::PIX_W-1:0] pixel,
	input  logic [ihd_pkg::PIX_W-1:0] above,
	pixel_out_if.source               pix_out,
	output ihd_pkg::avg_status_t      status
);
	import ihd_pkg::*;

	logic             valid_s1;
	pos_t             pos_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [PIX_W-1:0] held_q;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             out_row_end_q;
	logic             out_frame_end_q;

	logic [PIX_W-1:0] vert_avg;
	logic             has_result;
	logic             out_free;
	logic             s1_free;
	logic             take;

	// above lines up with stage 1: the line store read is registered
	assign vert_avg   = round_avg(above, pixel_s1);
	assign has_result = pos_s1.row_odd && pos_s1.col_odd;
	assign out_free   = !out_valid_q || pix_out.ready;
	assign s1_free    = !valid_s1 || !has_result || out_free;
	assign take       = valid_s1 && s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s1_free)
			valid_s1 <= load;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pos_s1   <= pos;
			pixel_s1 <= pixel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			held_q <= '0;
		else if (take && pos_s1.row_odd && !pos_s1.col_odd)
			held_q <= vert_avg;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_free)
			out_valid_q <= take && has_result;
	end

	always_ff @(posedge clk) begin
		if (out_free && take && has_result) begin
			out_pixel_q     <= round_avg(held_q, vert_avg);
			out_row_end_q   <= pos_s1.row_end;
			out_frame_end_q <= pos_s1.frame_end;
		end
	end

	assign pix_out.valid     = out_valid_q;
	assign pix_out.pixel_out = out_pixel_q;
	assign pix_out.row_end   = out_row_end_q;
	assign pix_out.frame_end = out_frame_end_q;

	always_comb begin
		status.s1_valid      = valid_s1;
		status.s1_free       = s1_free;
		status.s1_has_result = has_result;
	end
endmodule

// File: rtl/core/image_half_downsampler_unit.sv
// Top level of the 2x2 box-filter half downsampler.
//
// pix_in takes 8-bit gray pixels in raster order, one per cycle while ready. Pixels of
// even source rows go to a line store; on odd rows each pixel is averaged
// with the stored pixel above it, and every odd column gives one output
// pixel on pix_out: the rounding mean of the 2x2 block. A trailing odd
// column or odd row gives no output. row_end and frame_end mark the last
// output pixel of a row and of the frame.
// cfg writes image_width (index 0) and image_height (index 1); write only
// while the block is idle. cfg is always ready.
// The pixel that completes a block is registered in stage 1 alongside the
// registered line store read; its result is then held in the output register.
// Throughput: one input pixel per cycle while pix_in.ready is high; each
// transfer either writes the line store (even row) or reads it (odd row).
// Reset clears counters, held average and valid flags, and loads the size
// registers with 640 x 480. The line store is not cleared.
// When the receiver stalls, the output register holds its pixel; inputs are
// still taken until stage 1 also holds a pixel that produces a result.
`include "image_half_downsampler_unit_assert.svh"

module image_half_downsampler_unit (
	input  logic        clk,
	input  logic        arst_n,
	cfg_write_if.sink   cfg,
	pixel_in_if.sink    pix_in,
	pixel_out_if.source pix_out
);
	import ihd_pkg::*;

	pos_t        pos;
	avg_status_t status;
	logic        accept;
	logic [PIX_W-1:0] above;

	assign pix_in.ready = status.s1_free;
	assign accept       = pix_in.valid && pix_in.ready;

	ihd_position u_position (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (accept),
		.pos     (pos)
	);

	ihd_line_store u_line_store (
		.clk     (clk),
		.wr_en   (accept && !pos.row_odd),
		.wr_addr (pos.col),
		.wr_data (pix_in.pixel_in),
		.rd_en   (accept && pos.row_odd),
		.rd_addr (pos.col),
		.rd_data (above)
	);

	ihd_average u_average (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (accept),
		.pos     (pos),
		.pixel   (pix_in.pixel_in),
		.above   (above),
		.pix_out (pix_out),
		.status  (status)
	);

	`IHD_ASSERT_IMPL(a_frame_end_on_row_end, clk, arst_n,
		pix_out.valid && pix_out.frame_end, pix_out.row_end)
	`IHD_ASSERT_IMPL(a_in_stall_only_on_out_stall, clk, arst_n,
		!pix_in.ready, pix_out.valid && !pix_out.ready)
	`IHD_ASSERT_IMPL(a_s1_hold_has_result, clk, arst_n,
		status.s1_valid && !status.s1_free, status.s1_has_result)
	`IHD_ASSERT_NEXT(a_result_reaches_s1, clk, arst_n,
		accept && pos.row_odd && pos.col_odd, status.s1_valid && status.s1_has_result)
endmodule
